// ===== src/rrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg: shared types and constants of the round-robin run queue
// Field widths, command and status codes, and the item and result records.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int SLOT_W       = 4;
    localparam int TID_W        = 32;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [TID_W-1:0] ID_MAX      = '1;
    localparam logic [TID_W-1:0] ID_FIRST    = 32'd2;
    localparam logic [SLOT_W-1:0] IDLE_SLOT  = '0;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] task_slot;
        logic [TID_W-1:0]  given_tid;
        logic              current_running;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [TID_W-1:0]  assigned_tid;
        logic [SLOT_W-1:0] current_slot;
        logic [SLOT_W-1:0] previous_slot;
        logic              switched;
    } t_result;

endpackage

// ===== src/rrq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_mem: run queue storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rrq_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [rrq_pkg::SLOT_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [rrq_pkg::SLOT_W-1:0] o_rdata
);
    import rrq_pkg::*;

    logic [SLOT_W-1:0] r_store [DEPTH];
    logic [SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rrq_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_sched: scheduler sequencer
// Read the queue head on acceptance, then decide, write back and update.
// ----------------------------------------------------------------------------
module rrq_sched #(
    parameter int NUM_SLOTS = 16,
    parameter int PTR_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rrq_pkg::t_item             i_item,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output rrq_pkg::t_result           o_res,
    output logic                       o_mem_we,
    output logic [PTR_W-1:0]           o_mem_waddr,
    output logic [rrq_pkg::SLOT_W-1:0] o_mem_wdata,
    output logic                       o_mem_re,
    output logic [PTR_W-1:0]           o_mem_raddr,
    input  logic [rrq_pkg::SLOT_W-1:0] i_mem_rdata
);
    import rrq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);

    t_state            r_state, n_state;
    t_item             r_item;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_running, n_running;
    logic [TID_W-1:0]  r_next_id, n_next_id;

    logic    accept, commit, slot_bad, q_full, q_empty;
    t_result res;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign commit  = (r_state == S_EXEC) && i_res_take;

    assign slot_bad = (r_item.task_slot == IDLE_SLOT)
                   || (32'(r_item.task_slot) >= NUM_SLOTS);
    assign q_full   = (r_count == CNT_FULL);
    assign q_empty  = (r_count == '0);

    // Read the head for every item; only a tick with a non-empty queue uses it
    assign o_mem_re    = accept;
    assign o_mem_raddr = r_head;
    assign o_mem_waddr = r_tail;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_running   = r_running;
        n_next_id   = r_next_id;
        o_mem_we    = 1'b0;
        o_mem_wdata = r_item.task_slot;

        res.status        = ST_OK;
        res.assigned_tid  = '0;
        res.previous_slot = r_running;
        res.current_slot  = r_running;
        res.switched      = 1'b0;

        case (r_item.cmd)
            CMD_ADD: begin
                if (slot_bad) begin
                    res.status = ST_INVALID;
                end else if (q_full) begin
                    res.status = ST_FULL;
                end else begin
                    res.assigned_tid = r_item.given_tid;
                    if (r_item.given_tid == '0) begin
                        res.assigned_tid = r_next_id;
                        if (r_next_id != ID_MAX) begin
                            n_next_id = r_next_id + 1'b1;
                        end
                    end
                    o_mem_we = commit;
                    n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_TICK: begin
                if (!q_empty) begin
                    // Pop the head first, then re-queue a still-running task
                    res.current_slot = i_mem_rdata;
                    n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                    if (r_item.current_running) begin
                        o_mem_we    = commit;
                        o_mem_wdata = r_running;
                        n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    res.current_slot = r_item.current_running ? r_running : IDLE_SLOT;
                end
                n_running    = res.current_slot;
                res.switched = (res.current_slot != r_running);
            end
            default: ;
        endcase

        case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_running <= IDLE_SLOT;
            r_next_id <= ID_FIRST;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
                r_running <= n_running;
                r_next_id <= n_next_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_res_valid = (r_state == S_EXEC);
    assign o_res       = res;

endmodule

// ===== src/round_robin_run_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_run_queue_top: round-robin task scheduler with a FIFO run queue
// Queue of task slot numbers in a synchronous memory; add and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser selects add (0) or
//   tick (1); tdata carries the slot, the given id and the running flag.
//   m_axis returns one result per command: status, assigned id, current and
//   previous slot and the switch flag.
//   Each command passes the idle and exec states: in idle, acceptance issues
//   the read of the queue head; in exec the block sees the read data, writes
//   a tail entry where one is due and loads the output register once that
//   register is free. s_axis_tready then rises again, so the block takes no
//   new command before it is through with the last one; the result on m_axis
//   is registered. The queue memory has one read port and one write port.
//   A result waiting in the output register does not block acceptance; only
//   when it is still held and a second result is ready does the block hold
//   its command until m_axis_tready frees the register.
//   Reset leaves the idle task (slot 0) running, an empty queue
//   and next id 2; the queue memory needs no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_run_queue_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: task_slot[3:0], given_tid[35:4], current_running[36], zero fill
    input  logic [rrq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: cmd[0]
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: status[1:0], assigned_tid[33:2], current_slot[37:34],
    //        previous_slot[41:38], switched[42], zero fill
    output logic [rrq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);
    import rrq_pkg::*;

    localparam int PTR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    t_item             item;
    t_result           res;
    logic              res_valid, res_take;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  mem_waddr, mem_raddr;
    logic [SLOT_W-1:0] mem_wdata, mem_rdata;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    // Unpack the command fields
    assign item.cmd             = t_cmd'(s_axis_tuser);
    assign item.task_slot       = s_axis_tdata[3:0];
    assign item.given_tid       = s_axis_tdata[35:4];
    assign item.current_running = s_axis_tdata[36];

    rrq_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (PTR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rrq_sched #(
        .NUM_SLOTS (NUM_SLOTS),
        .PTR_W     (PTR_W),
        .CNT_W     (CNT_W)
    ) u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Output register: free when empty or drained in this cycle
    assign res_take = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_m_data <= {5'd0, res.switched, res.previous_slot, res.current_slot,
                         res.assigned_tid, res.status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== src/rrq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_checker: port-level checks of the run queue scheduler
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module rrq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [rrq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);
    import rrq_pkg::*;

    // A command takes the sequencer out of its idle state, which drops tready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("tready high in the cycle after a command transaction");

    // A switch only comes from a tick, which carries status ok and no id
    a_switch_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[42] |->
            m_axis_tdata[1:0] == ST_OK && m_axis_tdata[33:2] == '0)
        else $error("switch reported with a status or an id");

    // Without a switch the running slot is unchanged
    a_no_switch_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[42] |-> m_axis_tdata[37:34] == m_axis_tdata[41:38])
        else $error("slot changed without a switch");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

endmodule

bind round_robin_run_queue_top rrq_checker u_rrq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
